@@ sv/emrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrt_pkg
// Shared widths, codes and types of the exact-match route table.
// ----------------------------------------------------------------------------
package emrt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int CMD_W           = 2;
    localparam int KEY_W           = 32;
    localparam int QUEUE_W         = 8;
    localparam int IP_W            = 32;
    localparam int PORT_W          = 16;
    localparam int STATUS_W        = 3;
    localparam int SLOT_W          = 4;
    localparam int LIMIT_W         = 5;

    localparam logic [LIMIT_W-1:0] MAX_ROUTES_RESET = 5'd16;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_DELETE = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_UPDATED  = 3'd1;
    localparam status_t ST_DELETED  = 3'd2;
    localparam status_t ST_HIT      = 3'd3;
    localparam status_t ST_MISS     = 3'd4;
    localparam status_t ST_FULL     = 3'd5;
    localparam status_t ST_INVALID  = 3'd6;

    // route payload held in the data memory
    typedef struct packed {
        logic [QUEUE_W-1:0] queue_id;
        logic [IP_W-1:0]    hop_ip;
        logic [PORT_W-1:0]  hop_port;
    } entry_t;

    typedef struct packed {
        status_t            status;
        logic [QUEUE_W-1:0] found_queue;
        logic [IP_W-1:0]    found_ip;
        logic [PORT_W-1:0]  found_port;
        logic [SLOT_W-1:0]  slot;
    } result_t;

endpackage

@@ sv/emrt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emrt_if
// Handshake channels of the route table: command, result and limit write.
// ----------------------------------------------------------------------------
interface emrt_req_if;
    import emrt_pkg::*;

    logic               valid;
    logic               ready;
    cmd_t               command;
    logic [KEY_W-1:0]   dest_addr;
    logic [QUEUE_W-1:0] queue_id;
    logic [IP_W-1:0]    hop_ip;
    logic [PORT_W-1:0]  hop_port;

    modport source (output valid, command, dest_addr, queue_id, hop_ip, hop_port,
                    input ready);
    modport sink   (input valid, command, dest_addr, queue_id, hop_ip, hop_port,
                    output ready);
endinterface

interface emrt_rsp_if;
    import emrt_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [QUEUE_W-1:0] found_queue;
    logic [IP_W-1:0]    found_ip;
    logic [PORT_W-1:0]  found_port;
    logic [SLOT_W-1:0]  slot;

    modport source (output valid, status, found_queue, found_ip, found_port, slot,
                    input ready);
    modport sink   (input valid, status, found_queue, found_ip, found_port, slot,
                    output ready);
endinterface

interface emrt_cfg_if;
    import emrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] max_routes;

    modport source (output valid, max_routes, input ready);
    modport sink   (input valid, max_routes, output ready);
endinterface

@@ sv/exact_match_route_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_match_route_table
// Exact-match route table: add, delete and lookup by destination address.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          accepted on
//  req      in   command, dest_addr, queue_id, hop_ip, hop_port    valid & ready
//  rsp      out  status, found_queue, found_ip, found_port, slot   valid & ready
//  cfg      in   max_routes                                        valid & ready
//
//  One item at a time. A valid command scans the key memory one entry per
//  cycle over the used range, then decides; a lookup hit adds a data memory
//  read. Rejected items skip the scan and go straight to the output.
//  Reset empties the table at once; entries past the used count are never read.
//  A result waits in the output register; a stalled rsp holds the next result
//  in staging and keeps req not ready.
// ----------------------------------------------------------------------------
module exact_match_route_table #(
    parameter int TABLE_DEPTH = emrt_pkg::DEF_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    emrt_req_if.sink    req,
    emrt_rsp_if.source  rsp,
    emrt_cfg_if.sink    cfg
);
    import emrt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_LDATA  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] max_routes_reg;
    logic [CW-1:0]      used_reg, used_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               match_reg, match_next;
    logic [IW-1:0]      match_idx_reg, match_idx_next;
    logic               free_reg, free_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;

    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   addr_reg;
    entry_t             ent_reg;
    result_t            res_reg, res_next;
    result_t            out_reg;

    // memories
    logic [KEY_W-1:0]   key_mem [0:TABLE_DEPTH-1];
    entry_t             data_mem [0:TABLE_DEPTH-1];
    logic [KEY_W-1:0]   key_rd_reg;
    entry_t             data_rd_reg;

    logic               key_re, key_we, data_we, data_re;
    logic [IW-1:0]      key_wa, data_wa, data_ra;
    logic [KEY_W-1:0]   key_wd;

    logic               req_fire, req_ok, out_load, room;
    logic [IW-1:0]      ins_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid & req.ready;
    assign req_ok    = (req.dest_addr != '0) &&
                       ((req.command == CMD_ADD && req.queue_id != '0) ||
                        req.command == CMD_DELETE || req.command == CMD_LOOKUP);

    // used < min(max_routes, depth); used never exceeds depth
    assign room    = (CW'(used_reg) < DEPTH_C) &&
                     ({{(CW + LIMIT_W){1'b0}}, used_reg} <
                      {{CW{1'b0}}, {CW{1'b0}}, max_routes_reg});
    assign ins_idx = free_reg ? free_idx_reg : used_reg[IW-1:0];

    assign key_re  = (state_reg == S_SCAN) && (issue_reg < used_reg);
    assign out_load = (state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[issue_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= ent_reg;
        end
        if (data_re)
        begin
            data_rd_reg <= data_mem[data_ra];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        key_we         = 1'b0;
        key_wa         = match_idx_reg;
        key_wd         = addr_reg;
        data_we        = 1'b0;
        data_wa        = match_idx_reg;
        data_re        = 1'b0;
        data_ra        = match_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    issue_next = '0;
                    match_next = 1'b0;
                    free_next  = 1'b0;
                    res_next   = '0;
                    if (req_ok)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next.status = ST_INVALID;
                        state_next      = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (key_re)
                begin
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (!match_reg && key_rd_reg == addr_reg)
                    begin
                        match_next     = 1'b1;
                        match_idx_next = cmp_idx_reg;
                    end
                    if (!free_reg && key_rd_reg == '0)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
                if (!key_re && !cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                res_next.slot = SLOT_W'(match_idx_reg);
                priority case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (match_reg)
                        begin
                            key_we          = 1'b1;
                            data_we         = 1'b1;
                            res_next.status = ST_UPDATED;
                        end
                        else if (room)
                        begin
                            key_we          = 1'b1;
                            key_wa          = ins_idx;
                            data_we         = 1'b1;
                            data_wa         = ins_idx;
                            res_next.status = ST_INSERTED;
                            res_next.slot   = SLOT_W'(ins_idx);
                            if (!free_reg)
                            begin
                                used_next = used_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                            res_next.slot   = '0;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (match_reg)
                        begin
                            key_we          = 1'b1;
                            key_wd          = '0;
                            res_next.status = ST_DELETED;
                        end
                        else
                        begin
                            res_next.status = ST_MISS;
                            res_next.slot   = '0;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (match_reg)
                        begin
                            data_re    = 1'b1;
                            state_next = S_LDATA;
                        end
                        else
                        begin
                            res_next.status = ST_MISS;
                            res_next.slot   = '0;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_INVALID;
                        res_next.slot   = '0;
                    end
                endcase
            end
            S_LDATA:
            begin
                res_next.status      = ST_HIT;
                res_next.found_queue = data_rd_reg.queue_id;
                res_next.found_ip    = data_rd_reg.hop_ip;
                res_next.found_port  = data_rd_reg.hop_port;
                state_next           = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_routes_reg <= MAX_ROUTES_RESET;
            used_reg       <= '0;
            issue_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                max_routes_reg <= cfg.max_routes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
        if (req_fire)
        begin
            cmd_reg           <= req.command;
            addr_reg          <= req.dest_addr;
            ent_reg.queue_id  <= req.queue_id;
            ent_reg.hop_ip    <= req.hop_ip;
            ent_reg.hop_port  <= req.hop_port;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.found_queue = out_reg.found_queue;
    assign rsp.found_ip    = out_reg.found_ip;
    assign rsp.found_port  = out_reg.found_port;
    assign rsp.slot        = out_reg.slot;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exact-match route table. Commands go in on the
// req channel with random gaps. An in-bench copy of the table predicts each
// result, and every rsp item is checked field by field in arrival order.
// The route limit is stepped through its extremes between phases. One phase
// holds rsp off for a long stretch so that the table backs up into req.
// ----------------------------------------------------------------------------
module tb_top;
    import emrt_pkg::*;

    localparam int          DEPTH        = DEF_TABLE_DEPTH;
    localparam int          KEY_POOL     = 24;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          IDLE_PCT     = 36;
    localparam cmd_t        CMD_UNUSED   = 2'd3;
    localparam int          NUM_STATUS   = 7;

    logic clk;
    logic rst_n;

    emrt_req_if req_ch();
    emrt_rsp_if rsp_ch();
    emrt_cfg_if cfg_ch();

    exact_match_route_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // in-bench copy of the table
    logic [KEY_W-1:0]   route_key   [DEPTH];
    logic [QUEUE_W-1:0] route_queue [DEPTH];
    logic [IP_W-1:0]    route_ip    [DEPTH];
    logic [PORT_W-1:0]  route_port  [DEPTH];
    int                 route_used;
    logic [LIMIT_W-1:0] route_limit;

    result_t            route_expect_q[$];
    logic [KEY_W-1:0]   key_pool[KEY_POOL];

    bit  req_idle_en = 1'b1;
    bit  rsp_idle_en = 1'b1;
    int  rsp_hold    = 0;
    int  err_cnt     = 0;
    int  items_sent  = 0;
    int  results_got = 0;
    int  limit_writes = 0;
    int  status_seen[NUM_STATUS];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int find_route(logic [KEY_W-1:0] addr);
        for (int i = 0; i < route_used && i < DEPTH; i++)
        begin
            if (route_key[i] == addr)
                return i;
        end
        return DEPTH;
    endfunction

    function automatic void store_route(int i, logic [KEY_W-1:0] addr, logic [QUEUE_W-1:0] qid,
                                        logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
        route_key[i]   = addr;
        route_queue[i] = qid;
        route_ip[i]    = ip;
        route_port[i]  = port;
    endfunction

    function automatic result_t predict_route(cmd_t cmd, logic [KEY_W-1:0] addr,
                                              logic [QUEUE_W-1:0] qid, logic [IP_W-1:0] ip,
                                              logic [PORT_W-1:0] port);
        result_t r;
        int      hit;
        int      lim;
        int      i;
        r        = '0;
        r.status = ST_INVALID;
        lim      = (route_limit < DEPTH) ? int'(route_limit) : DEPTH;
        if (addr != '0)
        begin
            hit = find_route(addr);
            if (cmd == CMD_ADD && qid != '0)
            begin
                if (hit < DEPTH)
                begin
                    store_route(hit, addr, qid, ip, port);
                    r.status = ST_UPDATED;
                    r.slot   = hit[SLOT_W-1:0];
                end
                else if (route_used < lim)
                begin
                    // first freed slot below the used count, else append
                    i = 0;
                    while (i < route_used && route_key[i] != '0)
                        i++;
                    if (i == route_used)
                        route_used++;
                    store_route(i, addr, qid, ip, port);
                    r.status = ST_INSERTED;
                    r.slot   = i[SLOT_W-1:0];
                end
                else
                    r.status = ST_FULL;
            end
            else if (cmd == CMD_DELETE)
            begin
                if (hit < DEPTH)
                begin
                    route_key[hit] = '0;
                    r.status = ST_DELETED;
                    r.slot   = hit[SLOT_W-1:0];
                end
                else
                    r.status = ST_MISS;
            end
            else if (cmd == CMD_LOOKUP)
            begin
                if (hit < DEPTH)
                begin
                    r.status      = ST_HIT;
                    r.found_queue = route_queue[hit];
                    r.found_ip    = route_ip[hit];
                    r.found_port  = route_port[hit];
                    r.slot        = hit[SLOT_W-1:0];
                end
                else
                    r.status = ST_MISS;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // Entered at the step where the previous item was accepted (or right
    // after an edge with req low); returns at this item's accept step.
    task automatic send_cmd(cmd_t cmd, logic [KEY_W-1:0] addr, logic [QUEUE_W-1:0] qid,
                            logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
        if (req_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while (req_idle_en && $urandom_range(0, 99) < IDLE_PCT)
                @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.dest_addr <= addr;
        req_ch.queue_id  <= qid;
        req_ch.hop_ip    <= ip;
        req_ch.hop_port  <= port;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        route_expect_q.push_back(predict_route(cmd, addr, qid, ip, port));
        items_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (route_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] lim);
        drain_results();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.max_routes <= lim;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        route_limit = lim;
        limit_writes++;
    endtask

    // rsp side: random stalls, plus a counted hold-off when asked
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else
                rsp_ch.ready <= !(rsp_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("%t  mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(string fld, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      results_got, fld, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (route_expect_q.size() == 0)
                report_mismatch($sformatf("result %0d with no pending request", results_got));
            else
            begin
                want = route_expect_q.pop_front();
                check_field("status",      32'(rsp_ch.status),      32'(want.status));
                check_field("found_queue", 32'(rsp_ch.found_queue), 32'(want.found_queue));
                check_field("found_ip",    32'(rsp_ch.found_ip),    32'(want.found_ip));
                check_field("found_port",  32'(rsp_ch.found_port),  32'(want.found_port));
                check_field("slot",        32'(rsp_ch.slot),        32'(want.slot));
                if (want.status < NUM_STATUS)
                    status_seen[want.status]++;
            end
            results_got++;
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        int quiet;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("%t  watchdog: no handshake for %0d cycles, %0d results pending",
                     $realtime, quiet, route_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_and_invalid();
        send_cmd(CMD_LOOKUP, 32'h0BAD_F00D, 8'h11, 32'h0, 16'h0);
        send_cmd(CMD_DELETE, 32'h0BAD_F00D, 8'h11, 32'h0, 16'h0);
        send_cmd(CMD_ADD,    32'h0,         8'h22, 32'h0A00_0001, 16'd4791);
        send_cmd(CMD_ADD,    32'hC0A8_0001, 8'h00, 32'h0A00_0001, 16'd4791);
        send_cmd(CMD_UNUSED, 32'hC0A8_0001, 8'h22, 32'h0A00_0001, 16'd4791);
        send_cmd(CMD_LOOKUP, 32'h0,         8'h22, 32'h0, 16'h0);
        send_cmd(CMD_DELETE, 32'h0,         8'h22, 32'h0, 16'h0);
    endtask

    task automatic test_insert_update_delete();
        send_cmd(CMD_ADD,    32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_ADD,    32'h0000_0001, 8'h01, 32'h0, 16'h0);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_LOOKUP, 32'h0000_0001, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_ADD,    32'h0000_0001, 8'h80, 32'h8000_0000, 16'h8000);
        send_cmd(CMD_LOOKUP, 32'h0000_0001, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'h00, 32'h0, 16'h0);
        // freed slot 0 is reused, then a fresh key appends
        send_cmd(CMD_ADD,    32'h1234_5678, 8'h5A, 32'h0102_0304, 16'd53);
        send_cmd(CMD_ADD,    32'hA5A5_A5A5, 8'hA5, 32'h5A5A_5A5A, 16'h5A5A);
    endtask

    task automatic test_limit_edges();
        set_limit(5'd0);
        send_cmd(CMD_ADD, 32'h0000_0042, 8'h42, 32'h4242_4242, 16'h4242);
        send_cmd(CMD_ADD, 32'h0000_0001, 8'h03, 32'h0303_0303, 16'h0303);
        // limit below the used count: new keys are refused even with a hole
        set_limit(5'd1);
        send_cmd(CMD_ADD,    32'h0000_0042, 8'h42, 32'h4242_4242, 16'h4242);
        send_cmd(CMD_DELETE, 32'h0000_0001, 8'h00, 32'h0, 16'h0);
        send_cmd(CMD_ADD,    32'h0000_0042, 8'h42, 32'h4242_4242, 16'h4242);
        // above the table depth: capped
        set_limit(5'd31);
        send_cmd(CMD_ADD,    32'h0000_0042, 8'h42, 32'h4242_4242, 16'h4242);
    endtask

    task automatic send_random_cmd();
        int                 roll;
        cmd_t               cmd;
        logic [KEY_W-1:0]   addr;
        logic [QUEUE_W-1:0] qid;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            cmd = CMD_ADD;
        else if (roll < 65)
            cmd = CMD_DELETE;
        else
            cmd = CMD_LOOKUP;
        addr = key_pool[$urandom_range(0, KEY_POOL - 1)];
        qid  = QUEUE_W'($urandom_range(1, 255));
        // a minority of malformed items and keys outside the pool
        roll = $urandom_range(0, 99);
        if (roll < 4)
            cmd = CMD_UNUSED;
        else if (roll < 8)
            addr = '0;
        else if (roll < 12)
            qid = '0;
        else if (roll < 16)
            addr = $urandom;
        send_cmd(cmd, addr, qid, $urandom, PORT_W'($urandom));
    endtask

    task automatic test_random_limits();
        logic [LIMIT_W-1:0] lims[8];
        lims = '{5'd4, 5'd0, 5'd1, 5'd8, 5'd16, 5'd31, 5'd20, 5'd2};
        foreach (key_pool[i])
        begin
            key_pool[i] = $urandom;
            while (key_pool[i] == '0)
                key_pool[i] = $urandom;
        end
        key_pool[0] = '1;
        foreach (lims[p])
        begin
            set_limit(lims[p]);
            // one phase runs flat out on both sides
            req_idle_en = (lims[p] != 5'd16);
            rsp_idle_en = (lims[p] != 5'd16);
            repeat (60)
                send_random_cmd();
        end
        req_idle_en = 1'b1;
        rsp_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        drain_results();
        req_idle_en = 1'b0;
        rsp_hold    = 150;
        repeat (30)
            send_random_cmd();
        req_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_ADD;
        req_ch.dest_addr  <= '0;
        req_ch.queue_id   <= '0;
        req_ch.hop_ip     <= '0;
        req_ch.hop_port   <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.max_routes <= '0;
        foreach (route_key[i])
            store_route(i, '0, '0, '0, '0);
        route_used  = 0;
        route_limit = MAX_ROUTES_RESET;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_invalid();
        test_insert_update_delete();
        test_limit_edges();
        test_random_limits();
        test_backpressure();

        drain_results();
        repeat (40) @(posedge clk);
        if (route_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", route_expect_q.size()));

        $display("covered %0d commands, %0d results, %0d limit writes, final used count %0d",
                 items_sent, results_got, limit_writes, route_used);
        $display("ins %0d upd %0d del %0d hit %0d miss %0d full %0d inval %0d, errors %0d",
                 status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_DELETED],
                 status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_FULL],
                 status_seen[ST_INVALID], err_cnt);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
sv/emrt_pkg.sv
sv/emrt_if.sv
sv/exact_match_route_table.sv
verif/tb_top.sv
